@@ rtl/core/lcsc_pkg.sv @@
// Shared constants and helper functions for the luminance class stego codec.
package lcsc_pkg;

  localparam int PIX_W   = 8;
  localparam int CLASS_W = 3;
  localparam int LUMA_W  = 18;
  localparam int NUM_CLASSES = 1 << CLASS_W;

  // Integer luminance weights: 1000 times the usual 0.299, 0.587 and 0.114.
  localparam logic [LUMA_W-1:0] WEIGHT_RED   = LUMA_W'(299);
  localparam logic [LUMA_W-1:0] WEIGHT_GREEN = LUMA_W'(587);
  localparam logic [LUMA_W-1:0] WEIGHT_BLUE  = LUMA_W'(114);

  // One eighth of the full-scale weighted sum 255000.
  localparam logic [LUMA_W-1:0] LUMA_STEP = LUMA_W'(31875);

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  // Lower bound of class k, for k in 1..7.
  function automatic logic [LUMA_W-1:0] luma_threshold(input logic [CLASS_W-1:0] k);
    logic [2*LUMA_W-1:0] prod;
    prod = (2*LUMA_W)'(k) * (2*LUMA_W)'(LUMA_STEP);
    return prod[LUMA_W-1:0];
  endfunction

  // Gray level shown for a recovered class.
  function automatic logic [PIX_W-1:0] gray_of_class(input logic [CLASS_W-1:0] cls);
    logic [PIX_W-1:0] g;
    case (cls)
      3'd0:    g = 8'd0;
      3'd1:    g = 8'd37;
      3'd2:    g = 8'd74;
      3'd3:    g = 8'd111;
      3'd4:    g = 8'd147;
      3'd5:    g = 8'd183;
      3'd6:    g = 8'd219;
      default: g = 8'd255;
    endcase
    return g;
  endfunction

  // When on is set, raise a channel by one, or lower it by one when it sits at full scale.
  function automatic logic [PIX_W-1:0] nudge(input logic [PIX_W-1:0] v, input logic on);
    logic [PIX_W-1:0] r;
    if (!on) begin
      r = v;
    end else if (v == PIX_MAX) begin
      r = PIX_MAX - PIX_W'(1);
    end else begin
      r = v + PIX_W'(1);
    end
    return r;
  endfunction

  // True when two channels differ by exactly one in either direction.
  function automatic logic off_by_one(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
    logic [PIX_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == (PIX_W+1)'(1)) || (d == {(PIX_W+1){1'b1}});
  endfunction

endpackage

@@ rtl/core/luma_class_stego_codec.sv @@
// Top level of the luminance class stego codec: a three-stage pixel pipeline.
//
// Usage: one item is one pixel (pixel_red/green/blue) with its matching
// reference pixel (ref_red/green/blue). An item is accepted at a rising edge
// where in_valid is high and in_stall is low; a result is taken at an edge
// where out_valid is high and out_stall is low.
// In encode mode (decode_mode = 0) the block weighs the pixel into one of
// eight luminance classes and hides the class in the reference pixel, one
// bit per channel. In decode mode it recovers the class from a stego pixel
// and shows it as a gray level on all three channels.
// The mode register is written through cfg_write/cfg_wdata; the user
// must do so only while idle, as the block does not enforce it. An
// accepted item passes through the product stage, the sum stage and the
// compare and output stage, and out_valid rises with its result there.
// Throughput: one item per cycle while out_stall is low; each stage holds
// one item with its own valid bit, so bubbles close up while the output
// is stalled. A stalled result holds in the output register; in_stall
// rises only when all three stages are full and the receiver stalls.
// Reset (rst, synchronous) empties the pipeline and sets encode mode.
module luma_class_stego_codec (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] pixel_red,
  input  logic [7:0] pixel_green,
  input  logic [7:0] pixel_blue,
  input  logic [7:0] ref_red,
  input  logic [7:0] ref_green,
  input  logic [7:0] ref_blue,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [2:0] brightness_class
);

  localparam int PW = lcsc_pkg::PIX_W;
  localparam int CW = lcsc_pkg::CLASS_W;
  localparam int LW = lcsc_pkg::LUMA_W;

  // Mode register.
  logic decode_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode <= 1'b0;
    end else if (cfg_write) begin
      decode_mode <= cfg_wdata;
    end
  end

  // Stage 1: weighted channel products, and the decode class bits.
  logic          s1_valid;
  logic          s1_decode;
  logic [LW-1:0] s1_prod_red, s1_prod_green, s1_prod_blue;
  logic [PW-1:0] s1_ref_red, s1_ref_green, s1_ref_blue;
  logic [CW-1:0] s1_dec_class;

  // Stage 2: luminance sum.
  logic          s2_valid;
  logic          s2_decode;
  logic [LW-1:0] s2_sum;
  logic [PW-1:0] s2_ref_red, s2_ref_green, s2_ref_blue;
  logic [CW-1:0] s2_dec_class;

  // Stage 3 is the output register; out_decode rides along with it.
  logic out_decode;

  // A stage moves when it is empty or the stage after it moves.
  logic out_ready, s2_ready, s1_ready;
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2_valid  || out_ready;
  assign s1_ready  = !s1_valid  || s2_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_decode     <= decode_mode;
      s1_prod_red   <= lcsc_pkg::WEIGHT_RED   * LW'(pixel_red);
      s1_prod_green <= lcsc_pkg::WEIGHT_GREEN * LW'(pixel_green);
      s1_prod_blue  <= lcsc_pkg::WEIGHT_BLUE  * LW'(pixel_blue);
      s1_ref_red    <= ref_red;
      s1_ref_green  <= ref_green;
      s1_ref_blue   <= ref_blue;
      s1_dec_class  <= {lcsc_pkg::off_by_one(pixel_red,   ref_red),
                        lcsc_pkg::off_by_one(pixel_green, ref_green),
                        lcsc_pkg::off_by_one(pixel_blue,  ref_blue)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      s2_decode    <= s1_decode;
      s2_sum       <= s1_prod_red + s1_prod_green + s1_prod_blue;
      s2_ref_red   <= s1_ref_red;
      s2_ref_green <= s1_ref_green;
      s2_ref_blue  <= s1_ref_blue;
      s2_dec_class <= s1_dec_class;
    end
  end

  // Class from the sum: the highest k whose threshold the sum reaches.
  logic [CW-1:0] enc_class;
  logic [CW-1:0] s3_class;
  logic [PW-1:0] s3_red, s3_green, s3_blue, s3_gray;

  always_comb begin
    enc_class = '0;
    for (int k = 1; k < lcsc_pkg::NUM_CLASSES; k++) begin
      if (s2_sum >= lcsc_pkg::luma_threshold(CW'(k))) begin
        enc_class = CW'(k);
      end
    end
    s3_gray = lcsc_pkg::gray_of_class(s2_dec_class);
    if (s2_decode) begin
      s3_class = s2_dec_class;
      s3_red   = s3_gray;
      s3_green = s3_gray;
      s3_blue  = s3_gray;
    end else begin
      s3_class = enc_class;
      s3_red   = lcsc_pkg::nudge(s2_ref_red,   enc_class[2]);
      s3_green = lcsc_pkg::nudge(s2_ref_green, enc_class[1]);
      s3_blue  = lcsc_pkg::nudge(s2_ref_blue,  enc_class[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2_valid;
    end
    if (out_ready && s2_valid) begin
      out_decode       <= s2_decode;
      out_red          <= s3_red;
      out_green        <= s3_green;
      out_blue         <= s3_blue;
      brightness_class <= s3_class;
    end
  end

  // The input is held off only when every stage is full.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s2_valid && out_valid))
    else $error("input stalled while the pipeline has a free stage");

  // A decoded result shows its class as the same gray level on all channels.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_decode) |->
      (out_red == out_green && out_green == out_blue &&
       out_red == lcsc_pkg::gray_of_class(brightness_class)))
    else $error("decoded gray level does not match the class");

  // The sum stage, when it held an item and could not move, still holds it.
  assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !out_ready) |=> s2_valid)
    else $error("sum stage lost an item while stalled");

endmodule
